FILE: design/ptws_pkg.sv
// Shared types and constants for the peer table block.
// No dependencies; imported by every module of the block.
package ptws_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int LOAD_CEILING  = 101;
  localparam int MAX_LEFT      = 16;
  localparam int LIVE_MAX      = 31;
  localparam int SLOT_W        = 4;
  localparam int LIVE_W        = 5;

  localparam logic REG_SELF_ID = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    CMD_HEARTBEAT = 2'd0,
    CMD_SWEEP     = 2'd1,
    CMD_SELECT    = 2'd2,
    CMD_SELF      = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_UPDATED    = 4'd0,
    ST_JOINED     = 4'd1,
    ST_FULL       = 4'd2,
    ST_IGNORED    = 4'd3,
    ST_LEFT       = 4'd4,
    ST_SWEEP_DONE = 4'd5,
    ST_SELECTED   = 4'd6,
    ST_NONE       = 4'd7,
    ST_SELF_ADDED = 4'd8
  } status_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
    logic left;
    logic done;
  } ptws_ctl_t;

  typedef struct packed {
    logic idx_end;
    logic is_sweep;
  } ptws_stat_t;

endpackage

FILE: design/ptws_ctrl.sv
// Controller state machine for the peer table block.
// Depends on ptws_pkg; drives the datapath through ptws_ctl_t.
module ptws_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  ptws_pkg::ptws_stat_t   stat,
  output ptws_pkg::ptws_ctl_t    ctl
);
  import ptws_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_APPLY = 5'b00100,
    S_LEFT  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (stat.idx_end) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        ctl.apply = 1'b1;
        state_nxt = stat.is_sweep ? S_LEFT : S_IDLE;
      end
      S_LEFT: begin
        ctl.left = 1'b1;
        if (stat.idx_end) state_nxt = S_DONE;
      end
      S_DONE: begin
        ctl.done  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: design/ptws_dp.sv
// Datapath for the peer table block: entry table, scan registers, result register.
// Depends on ptws_pkg; sequenced by ptws_ctrl.
module ptws_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptws_pkg::ptws_ctl_t  ctl,
  output ptws_pkg::ptws_stat_t stat,
  input  logic [31:0]          self_id,
  input  logic [31:0]          timeout_ms,
  input  logic [1:0]           in_command,
  input  logic [31:0]          in_node_id,
  input  logic [31:0]          in_now_ms,
  input  logic [31:0]          in_ip_addr,
  input  logic [15:0]          in_port,
  input  logic [7:0]           in_capabilities,
  input  logic [7:0]           in_load,
  output logic                 out_valid,
  output logic [3:0]           out_status,
  output logic [31:0]          out_node_id_res,
  output logic [3:0]           out_slot,
  output logic [31:0]          out_ip_addr_res,
  output logic [15:0]          out_port_res,
  output logic [4:0]           out_live_count,
  output logic                 out_last
);
  import ptws_pkg::*;

  logic [TABLE_ENTRIES-1:0] online_r;
  logic [31:0] id_mem   [TABLE_ENTRIES];
  logic [31:0] seen_mem [TABLE_ENTRIES];
  logic [31:0] ip_mem   [TABLE_ENTRIES];
  logic [15:0] port_mem [TABLE_ENTRIES];
  logic [7:0]  caps_mem [TABLE_ENTRIES];
  logic [7:0]  load_mem [TABLE_ENTRIES];
  logic [CNT_W-1:0] occ_r, occ_nxt;

  cmd_t        cmd_r;
  logic [31:0] nid_r, now_r, ip_r;
  logic [15:0] port_r;
  logic [7:0]  caps_r, load_r;
  logic [IDX_W-1:0] idx_r;

  logic             match_found_r, free_found_r, best_found_r;
  logic [IDX_W-1:0] match_idx_r, free_idx_r, best_idx_r;
  logic [7:0]       best_load_r;
  logic [31:0]      best_id_r, best_ip_r;
  logic [15:0]      best_port_r;
  logic [TABLE_ENTRIES-1:0] mark_r;
  logic [CNT_W-1:0] ret_cnt_r;

  logic        e_on, peer, expired;
  logic [31:0] e_id, e_seen, key, age;

  logic             wr_en, wr_claim, wr_full;
  logic [IDX_W-1:0] wr_idx;
  logic [31:0]      wr_id;

  logic        emit;
  status_t     st;
  logic [31:0] o_id, o_ip;
  logic [15:0] o_port;
  logic [3:0]  o_slot;
  logic        o_last;
  logic [4:0]  o_live;

  logic        out_valid_r, out_last_r;
  logic [3:0]  out_status_r, out_slot_r;
  logic [31:0] out_id_r, out_ip_r;
  logic [15:0] out_port_r;
  logic [4:0]  out_live_r;

  assign e_on    = online_r[idx_r];
  assign e_id    = id_mem[idx_r];
  assign e_seen  = seen_mem[idx_r];
  assign key     = (cmd_r == CMD_SELF) ? self_id : nid_r;
  assign age     = now_r - e_seen;
  assign expired = age > timeout_ms;
  assign peer    = e_on && (e_id != self_id);

  assign stat.idx_end  = (idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign stat.is_sweep = (cmd_r == CMD_SWEEP);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r         <= cmd_t'(in_command);
      nid_r         <= in_node_id;
      now_r         <= in_now_ms;
      ip_r          <= in_ip_addr;
      port_r        <= in_port;
      caps_r        <= in_capabilities;
      load_r        <= in_load;
      idx_r         <= '0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      best_found_r  <= 1'b0;
      best_load_r   <= 8'(LOAD_CEILING);
      mark_r        <= '0;
      ret_cnt_r     <= '0;
    end else if (ctl.scan) begin
      idx_r <= idx_r + 1'b1;
      if (!match_found_r && e_on && (e_id == key)) begin
        match_found_r <= 1'b1;
        match_idx_r   <= idx_r;
      end
      if (!free_found_r && !e_on) begin
        free_found_r <= 1'b1;
        free_idx_r   <= idx_r;
      end
      if (peer && ((caps_mem[idx_r] & caps_r) == caps_r) &&
          (load_mem[idx_r] < best_load_r)) begin
        best_found_r <= 1'b1;
        best_idx_r   <= idx_r;
        best_load_r  <= load_mem[idx_r];
        best_id_r    <= e_id;
        best_ip_r    <= ip_mem[idx_r];
        best_port_r  <= port_mem[idx_r];
      end
      if (peer && expired && (32'(ret_cnt_r) < MAX_LEFT)) begin
        mark_r[idx_r] <= 1'b1;
        ret_cnt_r     <= ret_cnt_r + 1'b1;
      end
    end else if (ctl.apply) begin
      idx_r <= '0;
    end else if (ctl.left) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_comb begin
    emit     = 1'b0;
    st       = ST_NONE;
    o_id     = '0;
    o_ip     = '0;
    o_port   = '0;
    o_slot   = '0;
    o_last   = 1'b1;
    occ_nxt  = occ_r;
    wr_en    = 1'b0;
    wr_claim = 1'b0;
    wr_full  = 1'b0;
    wr_idx   = match_idx_r;
    wr_id    = key;
    priority if (ctl.apply) begin
      unique case (cmd_r)
        CMD_HEARTBEAT: begin
          emit = 1'b1;
          o_id = nid_r;
          priority if (nid_r == self_id) begin
            st = ST_IGNORED;
          end else if (match_found_r) begin
            st      = ST_UPDATED;
            o_slot  = SLOT_W'(match_idx_r);
            wr_en   = 1'b1;
            wr_full = 1'b1;
          end else if (free_found_r) begin
            st       = ST_JOINED;
            o_slot   = SLOT_W'(free_idx_r);
            wr_en    = 1'b1;
            wr_full  = 1'b1;
            wr_claim = 1'b1;
            wr_idx   = free_idx_r;
            occ_nxt  = occ_r + 1'b1;
          end else begin
            st = ST_FULL;
          end
        end
        CMD_SELF: begin
          emit = 1'b1;
          o_id = self_id;
          priority if (match_found_r) begin
            st     = ST_SELF_ADDED;
            o_slot = SLOT_W'(match_idx_r);
            wr_en  = 1'b1;
          end else if (free_found_r) begin
            st       = ST_SELF_ADDED;
            o_slot   = SLOT_W'(free_idx_r);
            wr_en    = 1'b1;
            wr_claim = 1'b1;
            wr_idx   = free_idx_r;
            occ_nxt  = occ_r + 1'b1;
          end else begin
            st = ST_FULL;
          end
        end
        CMD_SELECT: begin
          emit = 1'b1;
          if (best_found_r) begin
            st     = ST_SELECTED;
            o_id   = best_id_r;
            o_slot = SLOT_W'(best_idx_r);
            o_ip   = best_ip_r;
            o_port = best_port_r;
          end
        end
        CMD_SWEEP: occ_nxt = occ_r - ret_cnt_r;
        default: emit = 1'b0;
      endcase
    end else if (ctl.left) begin
      if (mark_r[idx_r]) begin
        emit   = 1'b1;
        st     = ST_LEFT;
        o_id   = e_id;
        o_slot = SLOT_W'(idx_r);
        o_last = 1'b0;
      end
    end else if (ctl.done) begin
      emit = 1'b1;
      st   = ST_SWEEP_DONE;
    end
    o_live = (32'(occ_nxt) > LIVE_MAX) ? LIVE_W'(LIVE_MAX) : LIVE_W'(occ_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      online_r <= '0;
      occ_r    <= '0;
    end else begin
      occ_r <= occ_nxt;
      if (ctl.left && mark_r[idx_r]) online_r[idx_r] <= 1'b0;
      if (wr_en && wr_claim) online_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        id_mem[i]   <= '0;
        seen_mem[i] <= '0;
        ip_mem[i]   <= '0;
        port_mem[i] <= '0;
        caps_mem[i] <= '0;
        load_mem[i] <= '0;
      end
    end else if (wr_en) begin
      seen_mem[wr_idx] <= now_r;
      port_mem[wr_idx] <= port_r;
      if (wr_claim) id_mem[wr_idx] <= wr_id;
      if (wr_full) begin
        ip_mem[wr_idx]   <= ip_r;
        caps_mem[wr_idx] <= caps_r;
        load_mem[wr_idx] <= load_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
    out_status_r <= st;
    out_id_r     <= o_id;
    out_slot_r   <= o_slot;
    out_ip_r     <= o_ip;
    out_port_r   <= o_port;
    out_live_r   <= o_live;
    out_last_r   <= o_last;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_node_id_res = out_id_r;
  assign out_slot        = out_slot_r;
  assign out_ip_addr_res = out_ip_r;
  assign out_port_res    = out_port_r;
  assign out_live_count  = out_live_r;
  assign out_last        = out_last_r;

endmodule

FILE: design/peer_table_with_timeout_and_select.sv
// Peer table top level: APB register file, controller and datapath.
// A request is loaded, the table is scanned entry by entry, then the result is registered.
// A sweep then walks the table once more to give its retired peers, followed by a done result.
// A new request is taken only while idle (busy low), so requests never overlap.
// Reset (rst_n low, synchronous): table empty, self_id 0, timeout_ms 15000.
// The receiver cannot stall: each result is held for exactly one cycle.
module peer_table_with_timeout_and_select (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_node_id,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_ip_addr,
  input  logic [15:0] in_port,
  input  logic [7:0]  in_capabilities,
  input  logic [7:0]  in_load,
  output logic        out_valid,
  output logic [3:0]  out_status,
  output logic [31:0] out_node_id_res,
  output logic [3:0]  out_slot,
  output logic [31:0] out_ip_addr_res,
  output logic [15:0] out_port_res,
  output logic [4:0]  out_live_count,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ptws_pkg::*;

  logic [31:0] self_id_r, timeout_r;
  logic        cfg_wr;
  ptws_ctl_t   ctl;
  ptws_stat_t  stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_TIMEOUT) ? timeout_r : self_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_id_r <= '0;
      timeout_r <= 32'd15000;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SELF_ID) self_id_r <= pwdata;
      else timeout_r <= pwdata;
    end
  end

  ptws_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctl   (ctl)
  );

  ptws_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .stat            (stat),
    .self_id         (self_id_r),
    .timeout_ms      (timeout_r),
    .in_command      (in_command),
    .in_node_id      (in_node_id),
    .in_now_ms       (in_now_ms),
    .in_ip_addr      (in_ip_addr),
    .in_port         (in_port),
    .in_capabilities (in_capabilities),
    .in_load         (in_load),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_node_id_res (out_node_id_res),
    .out_slot        (out_slot),
    .out_ip_addr_res (out_ip_addr_res),
    .out_port_res    (out_port_res),
    .out_live_count  (out_live_count),
    .out_last        (out_last)
  );

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request accepted without going busy");

  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without a request in progress");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_live_count) <= TABLE_ENTRIES))
    else $error("live count exceeds table size");
`endif

endmodule

FILE: tb/sv/tb_peer_table_with_timeout_and_select.sv
// Testbench for the peer table block: drives heartbeats, sweeps, selects and
// self-registrations, predicts every result and checks it. Depends on ptws_pkg
// and the peer_table_with_timeout_and_select RTL.
`timescale 1ns / 1ps

module tb_peer_table_with_timeout_and_select;
  import ptws_pkg::*;

  typedef struct {
    status_t     status;
    logic [31:0] node_id;
    logic [3:0]  slot;
    logic [31:0] ip_addr;
    logic [15:0] port;
    logic [4:0]  live_count;
    logic        last;
  } peer_res_t;

  class peer_table_sb;
    bit          online[16];
    logic [31:0] ids[16];
    logic [31:0] seen[16];
    logic [31:0] ips[16];
    logic [15:0] ports[16];
    logic [7:0]  caps[16];
    logic [7:0]  loads[16];
    int          occupied;
    logic [31:0] self_id;
    logic [31:0] timeout_ms;
    peer_res_t   pending[$];
    int          mismatches;

    function new();
      foreach (online[i]) begin
        online[i] = 0; ids[i] = 0; seen[i] = 0; ips[i] = 0;
        ports[i] = 0; caps[i] = 0; loads[i] = 0;
      end
      occupied = 0;
      self_id = 0;
      timeout_ms = 15000;
      mismatches = 0;
    endfunction

    function int find_or_claim(logic [31:0] id, output bit fresh);
      fresh = 0;
      for (int i = 0; i < 16; i++)
        if (online[i] && ids[i] == id) return i;
      for (int i = 0; i < 16; i++)
        if (!online[i]) begin
          online[i] = 1; ids[i] = id; occupied++; fresh = 1;
          return i;
        end
      return -1;
    endfunction

    function void add(status_t st, logic [31:0] id, int sl,
                      logic [31:0] ip, logic [15:0] pt);
      peer_res_t r;
      r.status = st; r.node_id = id; r.slot = sl[3:0];
      r.ip_addr = ip; r.port = pt; r.live_count = 0; r.last = 0;
      pending.push_back(r);
    endfunction

    function void note_request(cmd_t cmd, logic [31:0] nid, logic [31:0] now,
                               logic [31:0] ip, logic [15:0] pt,
                               logic [7:0] cp, logic [7:0] ld);
      int base, n, s, best;
      bit fresh;
      int lowest;
      base = pending.size();
      n = 0;
      case (cmd)
        CMD_HEARTBEAT: begin
          if (nid == self_id) begin
            add(ST_IGNORED, nid, 0, 0, 0);
          end else begin
            s = find_or_claim(nid, fresh);
            if (s < 0) begin
              add(ST_FULL, nid, 0, 0, 0);
            end else begin
              seen[s] = now; ips[s] = ip; ports[s] = pt; caps[s] = cp; loads[s] = ld;
              add(fresh ? ST_JOINED : ST_UPDATED, nid, s, 0, 0);
            end
          end
        end
        CMD_SWEEP: begin
          for (int i = 0; i < 16 && n < MAX_LEFT; i++) begin
            if (!online[i] || ids[i] == self_id) continue;
            if (now - seen[i] > timeout_ms) begin
              online[i] = 0; occupied--;
              add(ST_LEFT, ids[i], i, 0, 0);
              n++;
            end
          end
          add(ST_SWEEP_DONE, 0, 0, 0, 0);
        end
        CMD_SELECT: begin
          best = -1;
          lowest = LOAD_CEILING;
          for (int i = 0; i < 16; i++) begin
            if (!online[i] || ids[i] == self_id) continue;
            if ((caps[i] & cp) != cp) continue;
            if (int'(loads[i]) < lowest) begin
              lowest = int'(loads[i]); best = i;
            end
          end
          if (best < 0) add(ST_NONE, 0, 0, 0, 0);
          else add(ST_SELECTED, ids[best], best, ips[best], ports[best]);
        end
        default: begin
          s = find_or_claim(self_id, fresh);
          if (s < 0) begin
            add(ST_FULL, self_id, 0, 0, 0);
          end else begin
            seen[s] = now; ports[s] = pt;
            add(ST_SELF_ADDED, self_id, s, 0, 0);
          end
        end
      endcase
      for (int k = base; k < pending.size(); k++)
        pending[k].live_count = 5'((occupied > LIVE_MAX) ? LIVE_MAX : occupied);
      pending[pending.size() - 1].last = 1;
    endfunction

    function void check_result(peer_res_t got);
      peer_res_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d node %h", got.status, got.node_id);
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status || got.node_id !== exp.node_id ||
          got.slot !== exp.slot || got.ip_addr !== exp.ip_addr ||
          got.port !== exp.port || got.live_count !== exp.live_count ||
          got.last !== exp.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp st %0d id %h sl %0d ip %h pt %h lc %0d l %b",
                    " / got st %0d id %h sl %0d ip %h pt %h lc %0d l %b"},
                   exp.status, exp.node_id, exp.slot, exp.ip_addr, exp.port,
                   exp.live_count, exp.last, got.status, got.node_id, got.slot,
                   got.ip_addr, got.port, got.live_count, got.last);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_command = 0;
  logic [31:0] in_node_id = 0, in_now_ms = 0, in_ip_addr = 0;
  logic [15:0] in_port = 0;
  logic [7:0]  in_capabilities = 0, in_load = 0;
  logic        out_valid;
  logic [3:0]  out_status;
  logic [31:0] out_node_id_res, out_ip_addr_res;
  logic [3:0]  out_slot;
  logic [15:0] out_port_res;
  logic [4:0]  out_live_count;
  logic        out_last;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  peer_table_sb table_sb = new();
  int unsigned cycle_count = 0;
  logic [31:0] clock_ms = 0;
  logic [31:0] id_pool[8];

  always #2 clk = ~clk;

  peer_table_with_timeout_and_select i_dut (.*);

  always @(posedge clk) begin
    peer_res_t r;
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("tb_peer_table_with_timeout_and_select: FAIL");
      $finish;
    end
    if (rst_n && out_valid) begin
      r.status = status_t'(out_status); r.node_id = out_node_id_res;
      r.slot = out_slot; r.ip_addr = out_ip_addr_res; r.port = out_port_res;
      r.live_count = out_live_count; r.last = out_last;
      table_sb.check_result(r);
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == 3'd0) table_sb.self_id = value;
    else if (addr == 3'd4) table_sb.timeout_ms = value;
    @(posedge clk);
  endtask

  task automatic drain();
    while (table_sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send(cmd_t cmd, logic [31:0] nid, logic [31:0] now,
                      logic [31:0] ip, logic [15:0] pt,
                      logic [7:0] cp, logic [7:0] ld);
    start <= 1; in_command <= cmd; in_node_id <= nid; in_now_ms <= now;
    in_ip_addr <= ip; in_port <= pt; in_capabilities <= cp; in_load <= ld;
    @(posedge clk);
    while (busy) @(posedge clk);
    table_sb.note_request(cmd, nid, now, ip, pt, cp, ld);
    start <= 0;
    @(posedge clk);
  endtask

  task automatic random_request();
    int pick;
    logic [31:0] nid;
    pick = $urandom_range(0, 99);
    clock_ms += $urandom_range(0, 3000);
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
    nid = ($urandom_range(0, 4) == 0) ? $urandom : id_pool[$urandom_range(0, 7)];
    if (pick < 50)
      send(CMD_HEARTBEAT, nid, clock_ms, $urandom, 16'($urandom),
           8'($urandom),
           8'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 101)));
    else if (pick < 65)
      send(CMD_SWEEP, $urandom, clock_ms, $urandom, 16'($urandom), 8'($urandom),
           8'($urandom));
    else if (pick < 90)
      send(CMD_SELECT, $urandom, clock_ms, $urandom, 16'($urandom),
           8'($urandom & $urandom), 8'($urandom));
    else
      send(CMD_SELF, $urandom, clock_ms, $urandom, 16'($urandom), 8'($urandom),
           8'($urandom));
  endtask

  initial begin
    foreach (id_pool[i]) id_pool[i] = $urandom;
    id_pool[0] = 0;
    id_pool[1] = 32'hFFFF_FFFF;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, self handling, full table, sweeps and selects
    send(CMD_SELECT, 0, 0, 0, 0, 0, 0);
    send(CMD_HEARTBEAT, 0, 5, 1, 1, 8'hFF, 0);
    send(CMD_HEARTBEAT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
         8'hFF, 8'hFF);
    send(CMD_SELF, 7, 100, 0, 16'hFFFF, 0, 0);
    for (int i = 0; i < 16; i++)
      send(CMD_HEARTBEAT, 32'(32'h100 + i), 1000, 32'(32'hA000 + i), 16'(i),
           8'(8'h0F | i), 8'(100 - i));
    send(CMD_HEARTBEAT, 32'h1234, 1000, 0, 0, 0, 0);
    send(CMD_SELECT, 0, 0, 0, 0, 8'h0F, 0);
    send(CMD_SELECT, 0, 0, 0, 0, 8'hFF, 0);
    send(CMD_SWEEP, 0, 32'd200000, 0, 0, 0, 0);
    drain();

    write_reg(3'd0, 32'hFFFF_FFFF);
    write_reg(3'd4, 32'd1);
    send(CMD_HEARTBEAT, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    send(CMD_SELF, 0, 50, 0, 16'h1234, 0, 0);
    send(CMD_HEARTBEAT, 5, 50, 9, 9, 1, 101);
    send(CMD_SELECT, 0, 60, 0, 0, 0, 0);
    send(CMD_SWEEP, 0, 52, 0, 0, 0, 0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin write_reg(3'd0, $urandom); write_reg(3'd4, 32'hFFFF_FFFF); end
        1: begin write_reg(3'd0, id_pool[2]); write_reg(3'd4, 5000); end
        2: begin write_reg(3'd0, 0); write_reg(3'd4, 15000); end
        default: begin write_reg(3'd0, id_pool[3]); write_reg(3'd4, $urandom_range(1, 20000)); end
      endcase
      for (int n = 0; n < 58; ) begin
        int burst;
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst && n < 58; b++, n++) random_request();
        if ($urandom_range(0, 1)) repeat ($urandom_range(1, 30)) @(posedge clk);
      end
      drain();
    end

    if (table_sb.mismatches == 0 && table_sb.pending.size() == 0)
      $display("tb_peer_table_with_timeout_and_select: PASS");
    else
      $display("tb_peer_table_with_timeout_and_select: FAIL");
    $finish;
  end

endmodule
